// ===== src/lkvc_pkg.sv =====
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  localparam int PORT_KEY_W   = 16;
  localparam int PORT_VALUE_W = 16;
  localparam int CFG_CAP_W    = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_CAP_W-1:0] CAP_RESET = 5'd16;

  // register index is paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== src/lkvc_match.sv =====
// parallel key compare over all entries with lowest-index hit encode
module lkvc_match #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int IDX_W       = 4
) (
  input  logic [MAX_ENTRIES-1:0][KEY_BITS-1:0] keys,
  input  logic [MAX_ENTRIES-1:0]               valid,
  input  logic [KEY_BITS-1:0]                  key,
  output logic                                 hit,
  output logic [IDX_W-1:0]                     hit_idx
);

  logic [MAX_ENTRIES-1:0] match_vec;

  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      match_vec[j] = valid[j] && (keys[j] == key);
    end
  end

  // scan downwards so the lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if (match_vec[j]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

endmodule

// ===== src/lru_key_value_cache.sv =====
// fully associative key-value cache with least-recently-used replacement
//
// A get or put word enters an input register and is resolved from there: the key is
// compared against every entry at once, recency ranks, valid bits and the stored pair are
// updated, and a get loads its result into the output register. One word is taken per
// cycle while no get is stalled; the sustained rate is set by the lookup-and-update loop
// through the entry registers, and a get stalls only while the output register holds an
// untaken result. Puts give no output word. The user writes capacity through the APB port
// at address 0 only while the cache is idle; the block does not enforce this.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // tdata: key [15:0], value [31:16]
  input  logic [PORT_KEY_W+PORT_VALUE_W-1:0] in_tdata,
  // tuser: command
  input  logic [0:0]              in_tuser,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata: read_value [15:0]
  output logic [PORT_VALUE_W-1:0] out_tdata,
  // tuser: found
  output logic [0:0]              out_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;

  // configuration
  logic [CFG_CAP_W-1:0] cap_r;
  logic                 cfg_wr;

  // input register
  logic                  s1_valid_r;
  cmd_t                  s1_cmd_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic [VALUE_BITS-1:0] s1_value_r;
  logic                  s1_fire;

  // output register
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [PORT_VALUE_W-1:0] out_value_r;

  // entry state
  logic [MAX_ENTRIES-1:0][KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0]                val_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]               valid_r, valid_nxt;
  logic [IDX_W-1:0]                     rank_r [MAX_ENTRIES];
  logic [IDX_W-1:0]                     rank_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]                     count_r, count_nxt;

  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [CW-1:0]          cap_ext;
  logic [CNT_W-1:0]       eff_cap;
  logic [CW-1:0]          cap_m1;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [MAX_ENTRIES-1:0] valid_ev;
  logic                   need_evict;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  // apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[CFG_CAP_W-1:0];
    end
  end

  // capacity of zero acts as one, above the built depth acts as the depth
  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext[CNT_W-1:0];
    end
    cap_m1 = CW'(eff_cap) - CW'(1);
  end

  // handshakes
  assign s1_fire   = s1_valid_r && (s1_cmd_r == CMD_PUT || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= cmd_t'(in_tuser[0]);
      s1_key_r   <= KEY_BITS'(in_tdata[PORT_KEY_W-1:0]);
      s1_value_r <= VALUE_BITS'(in_tdata[PORT_KEY_W+PORT_VALUE_W-1:PORT_KEY_W]);
    end
  end

  lkvc_match #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .IDX_W       (IDX_W)
  ) u_match (
    .keys    (key_r),
    .valid   (valid_r),
    .key     (s1_key_r),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  // state update for one word
  always_comb begin
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_idx     = hit_idx;
    valid_ev   = valid_r;
    need_evict = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    if (s1_fire) begin
      if (hit) begin
        // promote the hit entry, age those that were more recent
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          if (valid_r[j] && (rank_r[j] < rank_r[hit_idx])) begin
            rank_nxt[j] = rank_r[j] + 1'b1;
          end
        end
        rank_nxt[hit_idx] = '0;
        if (s1_cmd_r == CMD_PUT) begin
          wr_en = 1'b1;
        end
      end else if (s1_cmd_r == CMD_PUT) begin
        // full: drop every entry ranked at or beyond capacity-1
        if (CW'(count_r) >= CW'(eff_cap)) begin
          need_evict = 1'b1;
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (valid_r[j] && (CW'(rank_r[j]) >= cap_m1)) begin
              valid_ev[j] = 1'b0;
              rank_nxt[j] = '0;
            end
          end
        end
        for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
          if (!valid_ev[j]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(j);
          end
        end
        valid_nxt = valid_ev;
        if (free_found) begin
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (valid_ev[j]) begin
              rank_nxt[j] = rank_r[j] + 1'b1;
            end
          end
          valid_nxt[free_idx] = 1'b1;
          rank_nxt[free_idx]  = '0;
          // ranks are dense, so an eviction always leaves capacity-1 behind
          count_nxt = need_evict ? eff_cap : count_r + 1'b1;
          wr_en     = 1'b1;
          wr_idx    = free_idx;
        end else if (need_evict) begin
          count_nxt = cap_m1[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r[wr_idx] <= s1_key_r;
      val_r[wr_idx] <= s1_value_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_cmd_r == CMD_GET) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd_r == CMD_GET) begin
      out_found_r <= hit;
      out_value_r <= hit ? PORT_VALUE_W'(val_r[hit_idx]) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_found_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("entry count differs from number of valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above depth");

  a_hit_most_recent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r == CMD_GET && hit) |=> (rank_r[$past(hit_idx)] == '0))
    else $error("hit entry not made most recent");

  a_put_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r == CMD_PUT && !out_valid_r) |=> !out_valid_r)
    else $error("put produced a result word");

endmodule
